/* rtl/prd_pkg.sv */
// shared types and constants for the palette run-length pixel decoder
package prd_pkg;

    localparam int CHUNK_SIZE   = 64;
    localparam int CHUNK_W      = 7;
    localparam int OFFS_W       = 6;
    localparam int LEN_W        = 6;
    localparam int STRIDE_W     = 21;
    localparam int OUT_INDEX_W  = 20;
    localparam int PAL_DEPTH    = 8;
    localparam int PAL_IDX_W    = 3;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_WORD_LSB = 2;
    localparam int TAIL_FLAG    = 4;

    localparam logic [0:0]          REG_STRIDE_PIXELS = 1'b0;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET      = 21'd4096;
    localparam logic [7:0]          COUNT_RESET       = 8'd255;
    localparam logic [7:0]          INDEX_RESET       = 8'd1;

    typedef enum logic [1:0] {
        PH_COUNT,
        PH_BLUE,
        PH_GREEN,
        PH_RED
    } t_phase;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    localparam t_rgb PAL_RESET = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};

    typedef struct packed {
        logic              valid;
        logic              over;
        logic [OFFS_W-1:0] pos;
        logic [LEN_W-1:0]  len;
    } t_run;

    typedef struct packed {
        t_run tail;
        t_run head;
        t_rgb rgb;
        logic opaque;
    } t_plan;

    typedef struct packed {
        logic                reload;
        logic [STRIDE_W-1:0] stride;
    } t_cfg;

endpackage

/* rtl/prd_front.sv */
// front end: header parsing, run code decoding and chunk bookkeeping
module prd_front #(
    parameter int INDEX_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  prd_pkg::t_cfg         i_cfg,
    input  logic                  i_push,
    input  logic [7:0]            i_data_byte,
    output logic                  o_full,
    input  logic                  i_q_full,
    output logic                  o_q_wr,
    output logic [INDEX_BITS-1:0] o_q_base,
    output prd_pkg::t_plan        o_q_plan
);
    import prd_pkg::*;

    t_rgb                  r_pal [PAL_DEPTH];
    t_phase                r_phase;
    logic [7:0]            r_cr;
    logic [7:0]            r_ci;
    logic                  r_pt;
    logic [3:0]            r_ph;
    logic [CHUNK_W-1:0]    r_cl;
    logic [OFFS_W-1:0]     r_ho;
    logic [OFFS_W-1:0]     r_to;
    logic [INDEX_BITS-1:0] r_cb;
    logic [STRIDE_W-1:0]   r_sl;

    t_phase                n_phase;
    logic [7:0]            n_cr;
    logic [7:0]            n_ci;
    logic                  n_pt;
    logic [3:0]            n_ph;
    logic [CHUNK_W-1:0]    n_cl;
    logic [OFFS_W-1:0]     n_ho;
    logic [OFFS_W-1:0]     n_to;

    logic                  accept;
    logic                  advance;
    logic                  restart;
    logic                  header_mode;
    logic [CHUNK_W-1:0]    cl_hk;
    logic [OFFS_W-1:0]     ho_hk;
    logic [OFFS_W-1:0]     to_hk;
    logic [INDEX_BITS-1:0] cb_hk;
    logic [STRIDE_W-1:0]   sl_hk;
    logic [STRIDE_W-1:0]   sl_e;
    logic [STRIDE_W-1:0]   stride_load;
    t_phase                phase_e;
    logic [7:0]            cr_e;
    logic [7:0]            ci_e;

    logic                  pal_we;
    logic [PAL_IDX_W-1:0]  pal_wr_idx;
    logic [PAL_IDX_W-1:0]  pal_rd_idx;

    logic                  run_go;
    logic [LEN_W-1:0]      tail_req;
    logic [LEN_W-1:0]      head_req;
    logic                  t_over;
    logic                  h_over;
    logic [CHUNK_W-1:0]    t_len;
    logic [CHUNK_W-1:0]    h_len;
    logic [CHUNK_W-1:0]    cl1;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;

    // chunk advance and stride restart ahead of each word
    always_comb begin
        advance     = (r_cl == '0);
        cl_hk       = advance ? CHUNK_W'(CHUNK_SIZE) : r_cl;
        ho_hk       = advance ? '0 : r_ho;
        to_hk       = advance ? OFFS_W'(CHUNK_SIZE - 1) : r_to;
        cb_hk       = advance ? r_cb + INDEX_BITS'(CHUNK_SIZE) : r_cb;
        if (!advance) begin
            sl_hk = r_sl;
        end else if (r_sl > STRIDE_W'(CHUNK_SIZE)) begin
            sl_hk = r_sl - STRIDE_W'(CHUNK_SIZE);
        end else begin
            sl_hk = '0;
        end
        stride_load = (i_cfg.stride == '0) ? STRIDE_W'(CHUNK_SIZE) : i_cfg.stride;
        restart     = (sl_hk == '0);
        sl_e        = restart ? stride_load : sl_hk;
        phase_e     = restart ? PH_COUNT : r_phase;
        cr_e        = restart ? COUNT_RESET : r_cr;
        ci_e        = restart ? INDEX_RESET : r_ci;
        header_mode = (cr_e != '0);
    end

    // header next state
    always_comb begin
        n_phase = phase_e;
        n_cr    = cr_e;
        n_ci    = ci_e;
        if (header_mode) begin
            case (phase_e)
                PH_COUNT: begin
                    n_cr    = i_data_byte;
                    n_phase = PH_BLUE;
                end
                PH_BLUE:  n_phase = PH_GREEN;
                PH_GREEN: n_phase = PH_RED;
                PH_RED: begin
                    n_phase = PH_BLUE;
                    n_ci    = ci_e + 8'd1;
                    n_cr    = cr_e - 8'd1;
                end
                default:  n_phase = PH_COUNT;
            endcase
        end else if (!r_pt) begin
            n_ci = {5'd0, i_data_byte[7:5]};
        end
    end

    // header outputs: palette entry writes, entries 1 to 7 only
    always_comb begin
        pal_wr_idx = ci_e[PAL_IDX_W-1:0];
        pal_we     = accept && header_mode && (phase_e != PH_COUNT)
                     && (ci_e[7:PAL_IDX_W] == '0) && (ci_e[PAL_IDX_W-1:0] != '0);
    end

    // run decoding and clipping against the pixels left in the chunk
    always_comb begin
        run_go     = !header_mode && (r_pt || !i_data_byte[TAIL_FLAG]);
        tail_req   = (run_go && r_pt) ? i_data_byte[5:0] : '0;
        if (!run_go) begin
            head_req = '0;
        end else if (r_pt) begin
            head_req = {r_ph, i_data_byte[7:6]};
        end else begin
            head_req = {2'd0, i_data_byte[3:0]};
        end
        t_over     = ({1'b0, tail_req} > cl_hk);
        t_len      = t_over ? cl_hk : {1'b0, tail_req};
        cl1        = cl_hk - t_len;
        h_over     = ({1'b0, head_req} > cl1);
        h_len      = h_over ? cl1 : {1'b0, head_req};
        n_cl       = cl1 - h_len;
        n_to       = to_hk - t_len[OFFS_W-1:0];
        n_ho       = ho_hk + h_len[OFFS_W-1:0];
        if (header_mode) begin
            n_pt = r_pt;
            n_ph = r_ph;
        end else if (r_pt) begin
            n_pt = 1'b0;
            n_ph = r_ph;
        end else begin
            n_pt = i_data_byte[TAIL_FLAG];
            n_ph = i_data_byte[3:0];
        end
        pal_rd_idx = r_pt ? ci_e[PAL_IDX_W-1:0] : i_data_byte[7:5];
    end

    always_comb begin
        o_q_base             = cb_hk;
        o_q_plan.tail.valid  = (t_len != '0);
        o_q_plan.tail.over   = t_over;
        o_q_plan.tail.pos    = to_hk;
        o_q_plan.tail.len    = t_len[LEN_W-1:0];
        o_q_plan.head.valid  = (h_len != '0);
        o_q_plan.head.over   = h_over;
        o_q_plan.head.pos    = ho_hk;
        o_q_plan.head.len    = h_len[LEN_W-1:0];
        o_q_plan.rgb         = r_pal[pal_rd_idx];
        o_q_plan.opaque      = (pal_rd_idx != '0);
        o_q_wr               = accept && (o_q_plan.tail.valid || o_q_plan.head.valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAL_DEPTH; i++) begin
                r_pal[i] <= (i == 0) ? '0 : PAL_RESET;
            end
            r_phase <= PH_COUNT;
            r_cr    <= COUNT_RESET;
            r_ci    <= INDEX_RESET;
            r_pt    <= 1'b0;
            r_ph    <= '0;
            r_cl    <= CHUNK_W'(CHUNK_SIZE);
            r_ho    <= '0;
            r_to    <= OFFS_W'(CHUNK_SIZE - 1);
            r_cb    <= '0;
            r_sl    <= STRIDE_RESET;
        end else begin
            if (i_cfg.reload) begin
                r_sl <= stride_load;
            end else if (accept) begin
                r_sl <= sl_e;
            end
            if (accept) begin
                r_phase <= n_phase;
                r_cr    <= n_cr;
                r_ci    <= n_ci;
                r_pt    <= n_pt;
                r_ph    <= n_ph;
                r_cl    <= n_cl;
                r_ho    <= n_ho;
                r_to    <= n_to;
                r_cb    <= cb_hk;
            end
            if (pal_we) begin
                case (phase_e)
                    PH_BLUE:  r_pal[pal_wr_idx].blue  <= i_data_byte;
                    PH_GREEN: r_pal[pal_wr_idx].green <= i_data_byte;
                    PH_RED:   r_pal[pal_wr_idx].red   <= i_data_byte;
                    default:  r_pal[pal_wr_idx]       <= r_pal[pal_wr_idx];
                endcase
            end
        end
    end

    a_chunk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cl <= CHUNK_W'(CHUNK_SIZE))
        else $error("chunk pixel count above chunk size");

    // head and tail offsets bracket the unfilled pixels whenever any are left
    a_offsets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cl != '0) |-> (({1'b0, r_ho} + r_cl) == ({1'b0, r_to} + CHUNK_W'(1))))
        else $error("head and tail offsets disagree with pixels left");

endmodule

/* rtl/prd_queue.sv */
// short run-plan queue between front and back
module prd_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_rd,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr;
    logic [PTR_W-1:0]  n_rd;
    logic              do_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_rd   = i_rd && !o_empty;
    assign n_wr    = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
    assign n_rd    = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wr <= n_wr;
            end
            if (do_rd) begin
                r_rd <= n_rd;
            end
            if (i_wr && !do_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_wr && do_rd) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("write into a full run queue");

endmodule

/* rtl/prd_back.sv */
// back end: turns queued run plans into descriptor words, one per cycle while the consumer pops
module prd_back #(
    parameter int INDEX_BITS = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_empty,
    input  logic [INDEX_BITS-1:0]              i_q_base,
    input  prd_pkg::t_plan                     i_q_plan,
    output logic                               o_q_pop,
    input  logic                               i_pop,
    output logic                               o_empty,
    output logic [prd_pkg::OUT_INDEX_W-1:0]    o_start_index,
    output logic [prd_pkg::LEN_W-1:0]          o_run_length,
    output logic                               o_descending,
    output logic [7:0]                         o_red,
    output logic [7:0]                         o_green,
    output logic [7:0]                         o_blue,
    output logic                               o_opaque,
    output logic                               o_last_run,
    output logic                               o_overrun
);
    import prd_pkg::*;

    logic                   r_out_valid;
    logic                   r_second;
    logic [OUT_INDEX_W-1:0] r_start;
    logic [LEN_W-1:0]       r_len;
    logic                   r_desc;
    t_rgb                   r_rgb;
    logic                   r_opaque;
    logic                   r_last;
    logic                   r_over;

    logic                   can_load;
    logic                   load;
    logic                   sel_tail;
    t_run                   run;
    logic [INDEX_BITS-1:0]  abs_index;

    always_comb begin
        can_load  = !r_out_valid || i_pop;
        load      = can_load && !i_q_empty;
        // tail run goes out first when the plan has one
        sel_tail  = i_q_plan.tail.valid && !r_second;
        run       = sel_tail ? i_q_plan.tail : i_q_plan.head;
        abs_index = i_q_base + INDEX_BITS'(run.pos);
        o_q_pop   = load && !(sel_tail && i_q_plan.head.valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            if (can_load) begin
                r_out_valid <= !i_q_empty;
            end
            if (load) begin
                r_second <= sel_tail && i_q_plan.head.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_start  <= OUT_INDEX_W'(abs_index);
            r_len    <= run.len;
            r_desc   <= sel_tail;
            r_rgb    <= i_q_plan.rgb;
            r_opaque <= i_q_plan.opaque;
            r_last   <= !(sel_tail && i_q_plan.head.valid);
            r_over   <= run.over;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_start_index = r_start;
    assign o_run_length  = r_len;
    assign o_descending  = r_desc;
    assign o_red         = r_rgb.red;
    assign o_green       = r_rgb.green;
    assign o_blue        = r_rgb.blue;
    assign o_opaque      = r_opaque;
    assign o_last_run    = r_last;
    assign o_overrun     = r_over;

    // the head half of a split plan must still be queued behind its tail word
    a_second_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (!i_q_empty && r_out_valid && r_desc && !r_last))
        else $error("head run pending without its plan in the queue");

endmodule

/* rtl/palette_run_length_pixel_decoder_unit.sv */
// Palette run-length pixel decoder: takes one stream byte per push and returns run descriptor
// words (up to two per byte) on a queue-style output. A byte is accepted in the cycle it is
// pushed whenever the run-plan queue between the parser and the descriptor stage has room, so
// bytes may arrive back to back. The descriptor stage hands out one word per cycle from its
// output register while the consumer pops, so a byte that causes two runs needs two output
// words and one that causes none needs none; the sustained byte rate is set by that output
// stage and depends on the run mix. The stride_pixels register sits at byte address 0 of the
// configuration port; writing it also restarts the stride count.
// No clearing pass follows reset.
module palette_run_length_pixel_decoder_unit #(
    parameter int INDEX_BITS  = 20,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [prd_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [prd_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [prd_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         i_data_byte,
    output logic                               empty,
    input  logic                               pop,
    output logic [prd_pkg::OUT_INDEX_W-1:0]    o_start_index,
    output logic [prd_pkg::LEN_W-1:0]          o_run_length,
    output logic                               o_descending,
    output logic [7:0]                         o_red,
    output logic [7:0]                         o_green,
    output logic [7:0]                         o_blue,
    output logic                               o_opaque,
    output logic                               o_last_run,
    output logic                               o_overrun
);
    import prd_pkg::*;

    localparam int ENTRY_W = INDEX_BITS + $bits(t_plan);

    logic [STRIDE_W-1:0]   r_stride;
    logic                  reg_hit;
    logic                  cfg_wr;
    t_cfg                  cfg;

    logic                  q_wr;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;
    logic [INDEX_BITS-1:0] wr_base;
    t_plan                 wr_plan;
    logic [ENTRY_W-1:0]    rd_entry;
    logic [INDEX_BITS-1:0] rd_base;
    t_plan                 rd_plan;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[CFG_ADDR_W-1:CFG_WORD_LSB] == REG_STRIDE_PIXELS);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? CFG_DATA_W'(r_stride) : '0;

    // front sees the value being written in the write cycle itself
    always_comb begin
        cfg.reload = cfg_wr;
        cfg.stride = cfg_wr ? pwdata[STRIDE_W-1:0] : r_stride;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_RESET;
        end else if (cfg_wr) begin
            r_stride <= pwdata[STRIDE_W-1:0];
        end
    end

    prd_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .o_full      (full),
        .i_q_full    (q_full),
        .o_q_wr      (q_wr),
        .o_q_base    (wr_base),
        .o_q_plan    (wr_plan)
    );

    prd_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  ({wr_base, wr_plan}),
        .i_rd    (q_pop),
        .o_data  (rd_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign rd_base = rd_entry[ENTRY_W-1 -: INDEX_BITS];
    assign rd_plan = rd_entry[$bits(t_plan)-1:0];

    prd_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_base      (rd_base),
        .i_q_plan      (rd_plan),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_start_index (o_start_index),
        .o_run_length  (o_run_length),
        .o_descending  (o_descending),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_opaque      (o_opaque),
        .o_last_run    (o_last_run),
        .o_overrun     (o_overrun)
    );

endmodule

/* test/tb_top.sv */
// self-checking testbench for the palette run-length pixel decoder unit
`timescale 1ns / 100ps

module tb_top;
    import prd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int IDLE_PCT      = 23;
    localparam int PHASE_ITEMS   = 290;
    localparam int MAX_SHOWN     = 10;
    localparam logic [CFG_ADDR_W-1:0] STRIDE_ADDR =
        CFG_ADDR_W'(REG_STRIDE_PIXELS) << CFG_WORD_LSB;

    typedef struct packed {
        logic [OUT_INDEX_W-1:0] start;
        logic [LEN_W-1:0]       len;
        logic                   desc;
        t_rgb                   rgb;
        logic                   opaque;
        logic                   last;
        logic                   over;
    } run_word_t;

    typedef enum logic {
        ROW_BYTE,
        ROW_STRIDE
    } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic [STRIDE_W-1:0] value;
        bit                  typed;
        run_word_t           want;
    } stim_row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr = '0;
    logic [CFG_DATA_W-1:0]  pwdata = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   push = 1'b0;
    logic                   full;
    logic [7:0]             i_data_byte = 8'h00;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [OUT_INDEX_W-1:0] o_start_index;
    logic [LEN_W-1:0]       o_run_length;
    logic                   o_descending;
    logic [7:0]             o_red;
    logic [7:0]             o_green;
    logic [7:0]             o_blue;
    logic                   o_opaque;
    logic                   o_last_run;
    logic                   o_overrun;

    // decoder image used for prediction
    t_rgb                   pal [PAL_DEPTH];
    t_phase                 hdr_phase;
    logic [7:0]             colours_left;
    logic [7:0]             pal_ptr;
    bit                     tail_due;
    logic [3:0]             head_hi;
    logic [CHUNK_W-1:0]     room;
    logic [OFFS_W-1:0]      head_pos;
    logic [OFFS_W-1:0]      tail_pos;
    logic [OUT_INDEX_W-1:0] base;
    logic [STRIDE_W-1:0]    stride_cnt;
    logic [STRIDE_W-1:0]    stride_reg;

    run_word_t              step_runs[$];
    run_word_t              expected_runs[$];
    stim_row_t              stim_rows[$];
    run_word_t              got_word;
    run_word_t              want_word;
    bit                     calm = 1'b0;
    int                     errors = 0;
    int                     shown = 0;
    int                     cycles = 0;
    int                     stride_plan[7] = '{64, 1048576, 0, 320, 100, 4096, 64};

    palette_run_length_pixel_decoder_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .i_data_byte   (i_data_byte),
        .empty         (empty),
        .pop           (pop),
        .o_start_index (o_start_index),
        .o_run_length  (o_run_length),
        .o_descending  (o_descending),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_opaque      (o_opaque),
        .o_last_run    (o_last_run),
        .o_overrun     (o_overrun)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [STRIDE_W-1:0] stride_reload();
        return (stride_reg == '0) ? STRIDE_W'(CHUNK_SIZE) : stride_reg;
    endfunction

    task automatic reset_image();
        pal[0] = '0;
        for (int i = 1; i < PAL_DEPTH; i++) pal[i] = PAL_RESET;
        hdr_phase = PH_COUNT;
        colours_left = COUNT_RESET;
        pal_ptr = INDEX_RESET;
        tail_due = 1'b0;
        head_hi = '0;
        room = CHUNK_W'(CHUNK_SIZE);
        head_pos = '0;
        tail_pos = OFFS_W'(CHUNK_SIZE - 1);
        base = '0;
        stride_reg = STRIDE_RESET;
        stride_cnt = stride_reload();
    endtask

    // clips the run to the pixels left in the chunk and queues its word
    task automatic emit_run(input int len, input bit down);
        run_word_t w;
        int        n;
        w = '0;
        n = len;
        if (n > int'(room)) begin
            n = int'(room);
            w.over = 1'b1;
        end
        if (n == 0) return;
        room = room - CHUNK_W'(n);
        if (down) begin
            w.start = base + OUT_INDEX_W'(tail_pos);
            tail_pos = tail_pos - OFFS_W'(n);
        end else begin
            w.start = base + OUT_INDEX_W'(head_pos);
            head_pos = head_pos + OFFS_W'(n);
        end
        w.len = LEN_W'(n);
        w.desc = down;
        w.rgb = pal[pal_ptr[PAL_IDX_W-1:0]];
        w.opaque = (pal_ptr[PAL_IDX_W-1:0] != '0);
        step_runs.push_back(w);
    endtask

    task automatic predict_byte(input logic [7:0] b);
        bit entry_ok;
        step_runs.delete();
        if (room == '0) begin
            room = CHUNK_W'(CHUNK_SIZE);
            base = base + OUT_INDEX_W'(CHUNK_SIZE);
            head_pos = '0;
            tail_pos = OFFS_W'(CHUNK_SIZE - 1);
            stride_cnt = (stride_cnt > STRIDE_W'(CHUNK_SIZE)) ?
                         stride_cnt - STRIDE_W'(CHUNK_SIZE) : '0;
        end
        if (stride_cnt == '0) begin
            hdr_phase = PH_COUNT;
            colours_left = COUNT_RESET;
            pal_ptr = INDEX_RESET;
            stride_cnt = stride_reload();
        end
        entry_ok = (pal_ptr >= 8'd1) && (pal_ptr < 8'(PAL_DEPTH));
        if (colours_left != '0) begin
            case (hdr_phase)
                PH_COUNT: begin
                    colours_left = b;
                    hdr_phase = PH_BLUE;
                end
                PH_BLUE: begin
                    if (entry_ok) pal[pal_ptr[PAL_IDX_W-1:0]].blue = b;
                    hdr_phase = PH_GREEN;
                end
                PH_GREEN: begin
                    if (entry_ok) pal[pal_ptr[PAL_IDX_W-1:0]].green = b;
                    hdr_phase = PH_RED;
                end
                default: begin
                    if (entry_ok) pal[pal_ptr[PAL_IDX_W-1:0]].red = b;
                    hdr_phase = PH_BLUE;
                    pal_ptr = pal_ptr + 8'd1;
                    colours_left = colours_left - 8'd1;
                end
            endcase
        end else if (tail_due) begin
            // second byte of a tail code: tail first, then the widened head
            tail_due = 1'b0;
            emit_run(int'(b[5:0]), 1'b1);
            emit_run(int'({head_hi, b[7:6]}), 1'b0);
        end else begin
            pal_ptr = {5'd0, b[7:5]};
            head_hi = b[3:0];
            if (b[TAIL_FLAG]) tail_due = 1'b1;
            else emit_run(int'(b[3:0]), 1'b0);
        end
        if (step_runs.size() > 0) step_runs[step_runs.size()-1].last = 1'b1;
    endtask

    // true when the next byte lands on a count byte of the header
    function automatic bit count_byte_next();
        logic [STRIDE_W-1:0] left;
        left = stride_cnt;
        if (room == '0)
            left = (left > STRIDE_W'(CHUNK_SIZE)) ? left - STRIDE_W'(CHUNK_SIZE) : '0;
        return (left == '0) || (colours_left != '0 && hdr_phase == PH_COUNT);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8 || !count_byte_next()) return 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 2) return 8'($urandom_range(0, 255));
        if (r < 25) return 8'($urandom_range(8, 15));
        return 8'($urandom_range(0, 7));
    endfunction

    task automatic add_byte_row(input logic [7:0] b);
        stim_rows.push_back('{ROW_BYTE, STRIDE_W'(b), 1'b0, '0});
    endtask

    task automatic add_checked_row(input logic [7:0] b, input run_word_t w);
        stim_rows.push_back('{ROW_BYTE, STRIDE_W'(b), 1'b1, w});
    endtask

    task automatic add_stride_row(input logic [STRIDE_W-1:0] v);
        stim_rows.push_back('{ROW_STRIDE, v, 1'b0, '0});
    endtask

    // each input cycle idles with the same odds as the output side
    task automatic take_break();
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed, input run_word_t w);
        i_data_byte <= b;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        predict_byte(b);
        if (typed) expected_runs.push_back(w);
        else foreach (step_runs[i]) expected_runs.push_back(step_runs[i]);
    endtask

    // wait for every expected word, then let header bytes drain
    task automatic settle();
        push <= 1'b0;
        while (expected_runs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_stride(input logic [STRIDE_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= STRIDE_ADDR;
        pwdata <= CFG_DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        stride_reg = v;
        stride_cnt = stride_reload();
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, expected_runs.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // output side: check each popped word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                got_word = {o_start_index, o_run_length, o_descending, o_red, o_green,
                            o_blue, o_opaque, o_last_run, o_overrun};
                if (expected_runs.size() == 0) begin
                    errors++;
                    if (shown < MAX_SHOWN) begin
                        shown++;
                        $display("unexpected word: start=%0d len=%0d desc=%0b rgb=%06h",
                                 got_word.start, got_word.len, got_word.desc, got_word.rgb);
                    end
                end else begin
                    want_word = expected_runs.pop_front();
                    if (got_word !== want_word) begin
                        errors++;
                        if (shown < MAX_SHOWN) begin
                            shown++;
                            $display("mismatch exp: start=%0d len=%0d desc=%0b rgb=%06h op=%0b last=%0b over=%0b",
                                     want_word.start, want_word.len, want_word.desc,
                                     want_word.rgb, want_word.opaque, want_word.last,
                                     want_word.over);
                            $display("         got: start=%0d len=%0d desc=%0b rgb=%06h op=%0b last=%0b over=%0b",
                                     got_word.start, got_word.len, got_word.desc,
                                     got_word.rgb, got_word.opaque, got_word.last,
                                     got_word.over);
                        end
                    end
                end
            end
            pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        reset_image();

        add_byte_row(8'h00);                                  // empty palette header
        add_checked_row(8'h0F, run_word_t'({20'd0, 6'd15, 1'b0, 24'h000000,
                                            1'b0, 1'b1, 1'b0}));
        add_byte_row(8'hFF);
        add_checked_row(8'hFF, run_word_t'({20'd63, 6'd49, 1'b1, 24'hFFFFFF,
                                            1'b1, 1'b1, 1'b1}));
        add_stride_row(21'd64);
        add_byte_row(8'h01);                                  // header reparse, one entry
        add_byte_row(8'h00);
        add_byte_row(8'h80);
        add_byte_row(8'hFF);
        add_byte_row(8'h30);
        add_byte_row(8'h41);                                  // tail and head in one byte
        add_byte_row(8'hE0);                                  // zero-length run
        add_byte_row(8'h2F);
        add_stride_row(21'd0);
        add_byte_row(8'hBF);
        add_byte_row(8'hFF);
        add_byte_row(8'h00);
        add_byte_row(8'h1F);
        add_byte_row(8'h3F);                                  // head clipped after tail
        add_stride_row(21'd100);
        add_byte_row(8'h41);
        add_byte_row(8'h5F);
        add_byte_row(8'h00);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_STRIDE) begin
                settle();
                write_stride(stim_rows[i].value);
            end else begin
                take_break();
                send_byte(stim_rows[i].value[7:0], stim_rows[i].typed, stim_rows[i].want);
            end
        end

        foreach (stride_plan[p]) begin
            settle();
            calm = (p == 3);
            write_stride(STRIDE_W'(stride_plan[p]));
            repeat (PHASE_ITEMS) begin
                take_break();
                send_byte(pick_byte(), 1'b0, '0);
            end
        end

        calm = 1'b0;
        settle();
        if (errors == 0 && expected_runs.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
